/* rtl/core/hed_pkg.sv */
package hed_pkg;

  // characters with a meaning of their own
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  localparam int unsigned NAME_CNT = 21;

  // names stored last character first, so character k sits at bits [8k+7:8k]
  localparam logic [63:0] NAME_TEXT [NAME_CNT] = '{
    64'("pma"),  64'("tl"),    64'("tg"),    64'("psbn"),  64'("touq"),
    64'("sopa"), 64'("tces"),  64'("orue"),  64'("dnuop"), 64'("tnec"),
    64'("ney"),  64'("ypoc"),  64'("ger"),   64'("edart"), 64'("lmuA"),
    64'("lmua"), 64'("lmuO"),  64'("lmuo"),  64'("lmuU"),  64'("lmuu"),
    64'("gilzs")
  };

  localparam logic [2:0] NAME_LEN [NAME_CNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3,
    3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5
  };

  // windows-1252 codes
  localparam logic [7:0] NAME_CODE [NAME_CNT] = '{
    8'h26, 8'h3C, 8'h3E, 8'hA0, 8'h22, 8'h27, 8'hA7, 8'h80, 8'hA3, 8'hA2, 8'hA5,
    8'hA9, 8'hAE, 8'h99, 8'hC4, 8'hE4, 8'hD6, 8'hF6, 8'hDC, 8'hFC, 8'hDF
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLAY,
    S_SEMI,
    S_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    CMD_ACCEPT,
    CMD_REPLAY,
    CMD_SEMI,
    CMD_FLUSH
  } cmd_op_e;

  typedef enum logic [2:0] {
    OC_PLAIN,
    OC_DROP,
    OC_SEMI,
    OC_ERROR,
    OC_OVERLONG
  } outcome_e;

  typedef struct packed {
    cmd_op_e op;
    logic    go;
  } dp_cmd_t;

  typedef struct packed {
    logic     can_emit;
    outcome_e outcome;
    logic     queue_end;
    logic     open_last;
    logic     semi_resume;
    logic     flush_end;
  } dp_stat_t;

  // bit 4 flags a digit, bits 3:0 its value
  function automatic logic [4:0] digit_val(input logic [7:0] ch, input logic hex);
    logic [4:0] r;
    r = '0;
    if (ch >= CH_0 && ch <= CH_9) begin
      r = {1'b1, 4'(ch - CH_0)};
    end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
      r = {1'b1, 4'(ch - CH_LA + 8'd10)};
    end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
      r = {1'b1, 4'(ch - CH_UA + 8'd10)};
    end
    return r;
  endfunction

endpackage

/* rtl/core/hed_ctrl.sv */
module hed_ctrl
  import hed_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     in_stall_o
);

  state_e state_q, state_d;
  logic   fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs
  always_comb begin
    cmd_o.op   = CMD_ACCEPT;
    fire       = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op   = CMD_ACCEPT;
        fire       = in_valid_i && stat_i.can_emit;
        in_stall_o = !stat_i.can_emit;
      end
      S_REPLAY: begin
        cmd_o.op = CMD_REPLAY;
        fire     = stat_i.can_emit;
      end
      S_SEMI: begin
        cmd_o.op = CMD_SEMI;
        fire     = stat_i.can_emit;
      end
      S_FLUSH: begin
        cmd_o.op = CMD_FLUSH;
        fire     = stat_i.can_emit;
      end
      default: begin
        cmd_o.op = CMD_ACCEPT;
      end
    endcase
    cmd_o.go = fire;
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (fire) begin
      unique case (state_q) inside
        S_IDLE, S_REPLAY: begin
          unique case (stat_i.outcome)
            OC_OVERLONG: state_d = S_REPLAY;
            OC_SEMI:     state_d = S_SEMI;
            OC_ERROR:    state_d = S_IDLE;
            OC_DROP:     state_d = S_IDLE;
            OC_PLAIN: begin
              if (stat_i.open_last) begin
                state_d = S_FLUSH;
              end else if (stat_i.queue_end) begin
                state_d = S_IDLE;
              end else begin
                state_d = S_REPLAY;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
        S_SEMI: begin
          state_d = stat_i.semi_resume ? S_REPLAY : S_IDLE;
        end
        S_FLUSH: begin
          state_d = stat_i.flush_end ? S_IDLE : S_FLUSH;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/hed_datapath.sv */
module hed_datapath
  import hed_pkg::*;
#(
  parameter int NAME_MAX = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  localparam int IDX_W = $clog2(NAME_MAX + 1);
  localparam int PIX_W = $clog2(NAME_MAX);

  // reference buffer and per-item registers
  logic [7:0]       pend_q [NAME_MAX];
  logic [IDX_W-1:0] count_q, idx_q;
  logic             ref_q, disc_q, last_q, semi_res_q;
  logic [7:0]       hold_q;

  // running decode of the buffered text
  logic                num_q, hex_q, stop_q, dig_q;
  logic [7:0]          val_q;
  logic [NAME_CNT-1:0] match_q, match_d;

  logic             out_valid_q, out_last_q, out_err_q;
  logic [7:0]       out_char_q;

  logic             can_emit, char_op, is_accept, idx_at_end, queue_end, step_last;
  logic [PIX_W-1:0] rd_idx;
  logic [7:0]       rd_ch, cur_ch, name_code, dec_v;
  logic [4:0]       dv;
  logic [7:0]       val_next;

  outcome_e   outcome;
  logic       emit, e_last, e_err, buf_wr, open_ref, close_ref, ref_after;
  logic [7:0] e_char;
  logic       ld, ld_last, ld_err;
  logic [7:0] ld_char;
  logic       flush_end;

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign is_accept  = cmd_i.op == CMD_ACCEPT;
  assign char_op    = is_accept || cmd_i.op == CMD_REPLAY;
  assign idx_at_end = idx_q == IDX_W'(NAME_MAX);
  assign queue_end  = is_accept || idx_at_end;
  assign step_last  = is_accept ? in_last_i : last_q;
  assign flush_end  = idx_q == count_q;

  // single read port on the buffer: flush reads one behind the index
  assign rd_idx = (cmd_i.op == CMD_FLUSH) ? PIX_W'(idx_q - 1'b1) : PIX_W'(idx_q);
  assign rd_ch  = pend_q[rd_idx];
  assign cur_ch = is_accept ? in_char_i : (idx_at_end ? hold_q : rd_ch);

  // name lookup from the running match vector
  always_comb begin
    name_code = '0;
    for (int i = 0; i < NAME_CNT; i++) begin
      if (match_q[i] && count_q == IDX_W'(NAME_LEN[i])) begin
        name_code = name_code | NAME_CODE[i];
      end
    end
  end

  assign dec_v = num_q ? (dig_q ? val_q : 8'd0) : name_code;

  // one character: plain text, a reference character, or a dropped byte
  always_comb begin
    outcome   = OC_PLAIN;
    emit      = 1'b0;
    e_char    = cur_ch;
    e_last    = 1'b0;
    e_err     = 1'b0;
    buf_wr    = 1'b0;
    open_ref  = 1'b0;
    close_ref = 1'b0;
    ref_after = ref_q;
    if (is_accept && disc_q) begin
      outcome = OC_DROP;
    end else if (!ref_q) begin
      if (cur_ch == CH_AMP) begin
        open_ref  = 1'b1;
        ref_after = 1'b1;
      end else begin
        emit   = 1'b1;
        e_last = step_last && queue_end;
      end
    end else if (cur_ch == CH_SEMI) begin
      close_ref = 1'b1;
      ref_after = 1'b0;
      emit      = 1'b1;
      if (count_q == '0) begin
        // empty reference passes through literally
        outcome = OC_SEMI;
        e_char  = CH_AMP;
      end else if (dec_v == 8'd0) begin
        outcome = OC_ERROR;
        e_char  = 8'd0;
        e_last  = 1'b1;
        e_err   = 1'b1;
      end else begin
        e_char = dec_v;
        e_last = step_last && queue_end;
      end
    end else if (count_q < IDX_W'(NAME_MAX)) begin
      buf_wr = 1'b1;
    end else begin
      outcome   = OC_OVERLONG;
      emit      = 1'b1;
      e_char    = CH_AMP;
      ref_after = 1'b0;
    end
  end

  always_comb begin
    stat_o.can_emit    = can_emit;
    stat_o.outcome     = outcome;
    stat_o.queue_end   = queue_end;
    stat_o.open_last   = step_last && ref_after && queue_end && outcome == OC_PLAIN;
    stat_o.semi_resume = semi_res_q;
    stat_o.flush_end   = flush_end;
  end

  // result selection
  always_comb begin
    ld      = 1'b0;
    ld_char = e_char;
    ld_last = e_last;
    ld_err  = e_err;
    unique case (cmd_i.op) inside
      CMD_ACCEPT, CMD_REPLAY: begin
        ld = cmd_i.go && emit;
      end
      CMD_SEMI: begin
        ld      = cmd_i.go;
        ld_char = CH_SEMI;
        ld_last = last_q && !semi_res_q;
        ld_err  = 1'b0;
      end
      CMD_FLUSH: begin
        ld      = cmd_i.go;
        ld_char = (idx_q == '0) ? CH_AMP : rd_ch;
        ld_last = flush_end;
        ld_err  = 1'b0;
      end
      default: ld = 1'b0;
    endcase
  end

  // next state of the running decode
  assign dv = digit_val(cur_ch, hex_q);
  assign val_next = hex_q ? 8'({val_q, 4'd0} + {8'd0, dv[3:0]})
                          : 8'({val_q, 3'd0} + {val_q, 1'b0} + {7'd0, dv[3:0]});

  always_comb begin
    for (int i = 0; i < NAME_CNT; i++) begin
      match_d[i] = (count_q == '0 || match_q[i])
                && count_q < IDX_W'(NAME_LEN[i])
                && NAME_TEXT[i][8*3'(count_q) +: 8] == cur_ch;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      ref_q       <= 1'b0;
      disc_q      <= 1'b0;
      last_q      <= 1'b0;
      semi_res_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.go && char_op) begin
        if (is_accept) begin
          last_q <= in_last_i;
        end
        semi_res_q <= !queue_end;
        if (outcome == OC_OVERLONG || queue_end) begin
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
        if (outcome == OC_DROP) begin
          if (in_last_i) begin
            disc_q <= 1'b0;
          end
        end
        if (open_ref || close_ref || outcome == OC_OVERLONG) begin
          ref_q   <= ref_after;
          count_q <= '0;
        end
        if (outcome == OC_ERROR) begin
          disc_q <= !step_last;
        end
        if (buf_wr) begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.go && cmd_i.op == CMD_FLUSH) begin
        idx_q <= idx_q + 1'b1;
        if (flush_end) begin
          ref_q   <= 1'b0;
          count_q <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_char_q <= ld_char;
      out_last_q <= ld_last;
      out_err_q  <= ld_err;
    end
    if (cmd_i.go && is_accept && outcome == OC_OVERLONG) begin
      hold_q <= cur_ch;
    end
    if (cmd_i.go && char_op && buf_wr) begin
      pend_q[PIX_W'(count_q)] <= cur_ch;
      match_q <= match_d;
      if (count_q == '0) begin
        num_q  <= cur_ch == CH_HASH;
        hex_q  <= 1'b0;
        stop_q <= 1'b0;
        dig_q  <= 1'b0;
        val_q  <= '0;
      end else if (num_q && !stop_q) begin
        if (count_q == IDX_W'(1) && cur_ch == CH_X) begin
          hex_q <= 1'b1;
        end else if (dv[4]) begin
          val_q <= val_next;
          dig_q <= 1'b1;
        end else begin
          stop_q <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_error_o = out_err_q;

endmodule

/* rtl/core/html_entity_decoder_top.sv */
// html character reference decoder
// input channel: one byte of a string per word (in_char_i) with in_last_i on the
//   final byte; a word moves when in_valid_i is high and in_stall_o is low
// output channel: decoded bytes (out_char_o) with out_last_o on the final word of
//   a string; out_error_o marks a string that failed to decode, given as one word
//   with out_last_o set, after which the rest of the string is dropped
// the first result of a word is loaded into the output register by the edge
//   that takes the word
// throughput: one input word per cycle while each word gives at most one result
//   and the output is not stalled; the controller emits one result per cycle
//   through the output register, so an empty reference sends its ';' in a state
//   of its own, a reference longer than NAME_MAX characters is replayed, and a
//   string that ends inside a reference is flushed as '&' and its buffer
// a stalled output holds its word; in_stall_o then rises, as the input side is
//   only taken when the output register is free or being emptied
// reset clears the controller, the reference state and the output valid; no
//   clearing pass is needed
module html_entity_decoder_top
  import hed_pkg::*;
#(
  parameter int NAME_MAX = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accept, replay of an overlong reference, trailing ';', flush at end
  hed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // reference buffer, running decode and output register
  hed_datapath #(
    .NAME_MAX (NAME_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .out_error_o (out_error_o)
  );

endmodule

/* tb/tb_html_entity_decoder_top.sv */
`timescale 1ns / 100ps

module tb_html_entity_decoder_top;
  import hed_pkg::*;

  localparam int NAME_LIMIT  = 6;
  localparam int HOLD_CYCLES = 80;       // long receiver hold-off
  localparam int DRAIN_CYCLES = 12;      // covers a full overlong replay
  localparam int CYCLE_LIMIT = 200000;   // many times the slowest correct run
  localparam int PHASE_WORDS = 28;       // random words per idling phase

  // one decoded word as seen on the output channel
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } result_t;

  // one row of stimulus; typed rows carry their single result written out
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic [7:0] ch_exp;
    logic       last_exp;
    logic       err_exp;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       out_last_o;
  logic       out_error_o;

  html_entity_decoder_top #(
    .NAME_MAX(NAME_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o),
    .out_error_o(out_error_o)
  );

  // named references and their windows-1252 codes
  string ent_name [21] = '{
    "amp", "lt", "gt", "nbsp", "quot", "apos", "sect", "euro", "pound", "cent", "yen",
    "copy", "reg", "trade", "Auml", "auml", "Ouml", "ouml", "Uuml", "uuml", "szlig"
  };
  logic [7:0] ent_code [21] = '{
    8'h26, 8'h3C, 8'h3E, 8'hA0, 8'h22, 8'h27, 8'hA7, 8'h80, 8'hA3, 8'hA2, 8'hA5,
    8'hA9, 8'hAE, 8'h99, 8'hC4, 8'hE4, 8'hD6, 8'hF6, 8'hDC, 8'hFC, 8'hDF
  };
  string hex_digits = "0123456789abcdefABCDEF";

  // decoder state as the predictor keeps it
  logic [7:0] ref_buf [NAME_LIMIT];
  int         ref_cnt;
  bit         ref_open;
  bit         dropping;

  // results of the word just accepted
  logic [7:0] res_ch   [NAME_LIMIT + 2];
  logic       res_last [NAME_LIMIT + 2];
  logic       res_err  [NAME_LIMIT + 2];
  int         res_n;

  // decoded words still to come out of the block, oldest first
  result_t    decoded_q [$];
  stim_row_t  directed_rows [$];

  // string under construction for the random part
  logic [7:0] str_buf [64];
  int         str_len;

  int send_idle;
  int recv_idle;
  int hold_req;
  int hold_seen;
  int fail_count;
  int cycle_count;

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int digit_of(input logic [7:0] c, input bit hex);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (hex && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (hex && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // value of the buffered reference; zero means the string fails
  function automatic logic [7:0] ref_value();
    int         n;
    int         pos;
    int         digits;
    int         d;
    int         i;
    int         k;
    bit         hex;
    bit         stop;
    bit         hit;
    logic [7:0] val;
    string      nm;
    n = ref_cnt;
    if (n >= 1 && ref_buf[0] == CH_HASH) begin
      // numeric: only the leading digits count, value wraps at 8 bits
      hex = (n >= 2 && ref_buf[1] == CH_X);
      pos = hex ? 2 : 1;
      digits = 0;
      val = 8'h00;
      stop = 1'b0;
      while (pos < n && !stop) begin
        d = digit_of(ref_buf[pos], hex);
        if (d < 0) begin
          stop = 1'b1;
        end else begin
          val = 8'(val * (hex ? 16 : 10) + d);
          digits++;
          pos++;
        end
      end
      return (digits != 0) ? val : 8'h00;
    end
    for (i = 0; i < 21; i++) begin
      nm = ent_name[i];
      if (nm.len() == n) begin
        hit = 1'b1;
        for (k = 0; k < n; k++) begin
          if (nm[k] != ref_buf[k]) hit = 1'b0;
        end
        if (hit) return ent_code[i];
      end
    end
    return 8'h00;
  endfunction

  task automatic note_result(input logic [7:0] c, input logic l, input logic e);
    if (res_n < NAME_LIMIT + 2) begin
      res_ch[res_n]   = c;
      res_last[res_n] = l;
      res_err[res_n]  = e;
      res_n++;
    end
  endtask

  // works out the words caused by one input word and moves the state on
  task automatic decode_byte(input logic [7:0] c0, input logic lst);
    logic [7:0] q   [2 * NAME_LIMIT + 2];
    logic [7:0] tmp [2 * NAME_LIMIT + 2];
    int         head;
    int         len;
    int         n;
    int         i;
    logic [7:0] c;
    logic [7:0] v;
    bit         failed;
    res_n = 0;
    failed = 1'b0;
    if (dropping) begin
      if (lst) dropping = 1'b0;
    end else begin
      q[0] = c0;
      head = 0;
      len = 1;
      while (head < len && !failed) begin
        c = q[head];
        head++;
        if (!ref_open) begin
          if (c == CH_AMP) begin
            ref_open = 1'b1;
            ref_cnt = 0;
          end else begin
            note_result(c, 1'b0, 1'b0);
          end
        end else if (c == CH_SEMI) begin
          ref_open = 1'b0;
          if (ref_cnt == 0) begin
            // empty reference passes through literally
            note_result(CH_AMP, 1'b0, 1'b0);
            note_result(CH_SEMI, 1'b0, 1'b0);
          end else begin
            v = ref_value();
            ref_cnt = 0;
            if (v == 8'h00) begin
              note_result(8'h00, 1'b1, 1'b1);
              dropping = !lst;
              failed = 1'b1;
            end else begin
              note_result(v, 1'b0, 1'b0);
            end
          end
        end else if (ref_cnt < NAME_LIMIT) begin
          ref_buf[ref_cnt] = c;
          ref_cnt++;
        end else begin
          // overlong: '&' goes out, buffer and rest are fed through again
          ref_open = 1'b0;
          note_result(CH_AMP, 1'b0, 1'b0);
          n = 0;
          for (i = 0; i < ref_cnt && n < 2 * NAME_LIMIT + 2; i++) begin
            tmp[n] = ref_buf[i];
            n++;
          end
          if (n < 2 * NAME_LIMIT + 2) begin
            tmp[n] = c;
            n++;
          end
          while (head < len && n < 2 * NAME_LIMIT + 2) begin
            tmp[n] = q[head];
            n++;
            head++;
          end
          ref_cnt = 0;
          for (i = 0; i < n; i++) q[i] = tmp[i];
          head = 0;
          len = n;
        end
      end
      if (!failed && lst) begin
        // string ends inside a reference: everything comes out literally
        if (ref_open) begin
          note_result(CH_AMP, 1'b0, 1'b0);
          for (i = 0; i < ref_cnt; i++) note_result(ref_buf[i], 1'b0, 1'b0);
          ref_open = 1'b0;
          ref_cnt = 0;
        end
        if (res_n > 0) res_last[res_n - 1] = 1'b1;
      end
    end
  endtask

  // offers one word at the falling edge, holds it until taken at a rising edge
  task automatic drive_word(input stim_row_t row);
    int      k;
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= row.ch;
    in_last_i  <= row.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(row.ch, row.last);
    if (row.typed) begin
      r.ch = row.ch_exp;
      r.last = row.last_exp;
      r.err = row.err_exp;
      decoded_q.push_back(r);
    end else begin
      for (k = 0; k < res_n; k++) begin
        r.ch = res_ch[k];
        r.last = res_last[k];
        r.err = res_err[k];
        decoded_q.push_back(r);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] c, input logic l, input logic typed,
                         input logic [7:0] ce, input logic le, input logic ee);
    stim_row_t row;
    row.ch = c;
    row.last = l;
    row.typed = typed;
    row.ch_exp = ce;
    row.last_exp = le;
    row.err_exp = ee;
    directed_rows.push_back(row);
  endtask

  // untyped row: the predictor supplies the results
  task automatic add_plain(input logic [7:0] c, input logic l);
    add_row(c, l, 1'b0, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic put_char(input logic [7:0] c);
    if (str_len < 64) begin
      str_buf[str_len] = c;
      str_len++;
    end
  endtask

  function automatic logic [7:0] any_byte();
    return 8'(1 + $urandom_range(254));
  endfunction

  function automatic logic [7:0] letter();
    return CH_LA + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] dec_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  // builds one random string, mostly well formed, and sends it
  task automatic send_string(inout int sent);
    int        segs;
    int        s;
    int        k;
    string     nm;
    stim_row_t row;
    str_len = 0;
    segs = 1 + $urandom_range(3);
    for (s = 0; s < segs; s++) begin
      case ($urandom_range(9)) inside
        [0:3]: begin
          // plain text
          repeat (1 + $urandom_range(2)) begin
            row.ch = any_byte();
            if (row.ch == CH_AMP) row.ch = CH_AMP + 8'd1;
            put_char(row.ch);
          end
        end
        [4:5]: begin
          nm = ent_name[$urandom_range(20)];
          put_char(CH_AMP);
          for (k = 0; k < nm.len(); k++) put_char(nm[k]);
          put_char(CH_SEMI);
        end
        6: begin
          put_char(CH_AMP);
          put_char(CH_HASH);
          put_char(CH_X);
          repeat (1 + $urandom_range(3)) put_char(hex_digits[$urandom_range(21)]);
          put_char(CH_SEMI);
        end
        7: begin
          put_char(CH_AMP);
          put_char(CH_HASH);
          repeat (1 + $urandom_range(4)) put_char(dec_digit());
          put_char(CH_SEMI);
        end
        8: begin
          put_char(CH_AMP);
          case ($urandom_range(4))
            0: begin
              // likely an unknown name
              repeat (1 + $urandom_range(5)) put_char(letter());
              put_char(CH_SEMI);
            end
            1: repeat (7 + $urandom_range(2)) put_char(letter());
            2: put_char(CH_SEMI);
            3: begin
              // upper-case x is not hex; trailing junk after digits
              put_char(CH_HASH);
              put_char($urandom_range(1) ? "X" : dec_digit());
              put_char(dec_digit());
              put_char(letter());
              put_char(CH_SEMI);
            end
            default: repeat ($urandom_range(3)) put_char(letter());
          endcase
        end
        default: repeat (1 + $urandom_range(3)) put_char(any_byte());
      endcase
    end
    row.typed = 1'b0;
    row.ch_exp = 8'h00;
    row.last_exp = 1'b0;
    row.err_exp = 1'b0;
    for (k = 0; k < str_len; k++) begin
      row.ch = str_buf[k];
      row.last = (k == str_len - 1);
      drive_word(row);
      sent++;
    end
  endtask

  // sender pauses until every decoded word is out, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // output checker: every word taken is compared with the oldest expectation
  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word char %h last %b error %b", $time,
                 out_char_o, out_last_o, out_error_o);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_char_o !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char_o);
          fail_count++;
        end
        if (out_last_o !== want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last_o);
          fail_count++;
        end
        if (out_error_o !== want.err) begin
          $display("%0t: out_error expected %b actual %b", $time, want.err, out_error_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int  p;
    int  i;
    int  sent;
    bit  held;
    fail_count = 0;
    cycle_count = 0;
    hold_req = 0;
    send_idle = 17;
    recv_idle = 57;
    ref_cnt = 0;
    ref_open = 1'b0;
    dropping = 1'b0;
    in_valid_i = 1'b0;
    in_char_i = 8'h20;
    in_last_i = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words
    add_row("A", 1'b0, 1'b1, "A", 1'b0, 1'b0);          // first word after reset
    add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);      // top byte
    add_row(8'h01, 1'b1, 1'b1, 8'h01, 1'b1, 1'b0);      // bottom byte ends a string
    add_plain(CH_AMP, 1'b0);                            // named reference
    add_plain("l", 1'b0);
    add_plain("t", 1'b0);
    add_row(CH_SEMI, 1'b1, 1'b1, 8'h3C, 1'b1, 1'b0);
    add_plain(CH_AMP, 1'b0);                            // empty reference
    add_plain(CH_SEMI, 1'b1);
    add_plain(CH_AMP, 1'b0);                            // overlong, eight words out
    add_plain("a", 1'b0);
    add_plain("b", 1'b0);
    add_plain("c", 1'b0);
    add_plain("d", 1'b0);
    add_plain("e", 1'b0);
    add_plain("f", 1'b0);
    add_plain("g", 1'b1);
    add_plain(CH_AMP, 1'b0);                            // string ends inside a reference
    add_plain("q", 1'b1);
    add_plain(CH_AMP, 1'b0);                            // numeric with no digits
    add_plain(CH_HASH, 1'b0);
    add_row(CH_SEMI, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1);
    add_plain("Z", 1'b0);                               // dropped
    add_plain("Y", 1'b1);                               // dropped, ends the string
    add_plain(CH_AMP, 1'b0);                            // unknown name on the last byte
    add_plain("x", 1'b0);
    add_row(CH_SEMI, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
    @(negedge clk_i);
    for (i = 0; i < directed_rows.size(); i++) drive_word(directed_rows[i]);
    drain();

    // random strings: three idling phases
    held = 1'b0;
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 17;
          recv_idle = 57;
        end
        1: begin
          send_idle = 57;
          recv_idle = 17;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // one long hold-off while the sender keeps offering words
        if (p == 0 && !held && sent > 12) begin
          hold_req++;
          held = 1'b1;
        end
        send_string(sent);
      end
      drain();
    end

    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/hed_pkg.sv
rtl/core/hed_ctrl.sv
rtl/core/hed_datapath.sv
rtl/core/html_entity_decoder_top.sv
tb/tb_html_entity_decoder_top.sv
